/* src/pmaqi_pkg.sv */
package pmaqi_pkg;

   // window and self-test sizes
   localparam int unsigned WINDOW_DEPTH = 5;
   localparam int unsigned SELFTEST_LEN = 3;

   // field widths
   localparam int unsigned RAW_W = 16;
   localparam int unsigned MED_W = 20;
   localparam int unsigned AQI_W = 13;

   // stream word widths
   localparam int unsigned REQ_TDATA_W = 48;
   localparam int unsigned RSP_TDATA_W = 64;
   localparam int unsigned RSP_PAD_W   = RSP_TDATA_W - 3 * RAW_W - AQI_W - 1;

   // counter widths
   localparam int unsigned SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned TEST_W = $clog2(SELFTEST_LEN + 1);

   // a self-test reading above this is bad
   localparam int unsigned SELF_TEST_MAX = 500;

   // floor(16*x/53) by reciprocal, exact for x below 2**21
   localparam int unsigned RECIP53_SHIFT = 27;
   localparam int unsigned RECIP53_W     = 22;
   localparam logic [RECIP53_W-1:0] RECIP53 =
      RECIP53_W'(((64'd1 << RECIP53_SHIFT) + 64'd52) / 64'd53);
   localparam int unsigned CORR_PROD_W = RAW_W + 4 + RECIP53_W;
   localparam int unsigned CORR_QUOT_W = CORR_PROD_W - RECIP53_SHIFT;

   // pm2.5 aqi breakpoints in tenths
   localparam int unsigned AQI_BANDS     = 7;
   localparam int unsigned BAND_W        = $clog2(AQI_BANDS);
   localparam int unsigned AQI_IN_W      = 13;
   localparam int unsigned AQI_SPAN_W    = 11;
   localparam int unsigned AQI_FRAC_BITS = 24;
   localparam int unsigned AQI_SCALE_W   = 27;
   localparam logic [AQI_IN_W-1:0] AQI_CAP = AQI_IN_W'(5004);

   localparam logic [AQI_IN_W-1:0] AQI_TOP [AQI_BANDS] = '{
      13'd120, 13'd354, 13'd554, 13'd1504, 13'd2504, 13'd3504, 13'd5004};
   localparam logic [AQI_IN_W-1:0] AQI_LO [AQI_BANDS] = '{
      13'd0, 13'd121, 13'd355, 13'd555, 13'd1505, 13'd2505, 13'd3505};
   localparam logic [AQI_W-1:0] AQI_BASE [AQI_BANDS] = '{
      13'd0, 13'd510, 13'd1010, 13'd1510, 13'd2010, 13'd3010, 13'd4010};

   // ceil(10*(ah-al) * 2**24 / (ch-cl)) per band
   localparam logic [AQI_SCALE_W-1:0] AQI_SCALE [AQI_BANDS] = '{
      AQI_SCALE_W'(((64'd500 << AQI_FRAC_BITS) + 64'd119) / 64'd120),
      AQI_SCALE_W'(((64'd490 << AQI_FRAC_BITS) + 64'd232) / 64'd233),
      AQI_SCALE_W'(((64'd490 << AQI_FRAC_BITS) + 64'd198) / 64'd199),
      AQI_SCALE_W'(((64'd490 << AQI_FRAC_BITS) + 64'd948) / 64'd949),
      AQI_SCALE_W'(((64'd990 << AQI_FRAC_BITS) + 64'd998) / 64'd999),
      AQI_SCALE_W'(((64'd990 << AQI_FRAC_BITS) + 64'd998) / 64'd999),
      AQI_SCALE_W'(((64'd990 << AQI_FRAC_BITS) + 64'd1498) / 64'd1499)};

   typedef logic [RAW_W-1:0]  raw_type;
   typedef logic [MED_W-1:0]  med_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [TEST_W-1:0] test_type;
   typedef logic [AQI_W-1:0]  aqi_type;

endpackage

/* src/pmaqi_median.sv */
module pmaqi_median (
   input  pmaqi_pkg::med_type vals [pmaqi_pkg::WINDOW_DEPTH],
   input  pmaqi_pkg::cnt_type count,
   output pmaqi_pkg::med_type median
);
   import pmaqi_pkg::*;

   cnt_type rank [WINDOW_DEPTH];
   cnt_type half;

   // rank of each used entry, ties broken by slot
   always_comb begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         rank[i] = '0;
         for (int j = 0; j < WINDOW_DEPTH; j++) begin
            if ((CNT_W'(j) < count) && (j != i) &&
                ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i)))) begin
               rank[i] = rank[i] + CNT_W'(1);
            end
         end
      end
   end

   // upper median picks rank count/2
   assign half = count >> 1;

   always_comb begin
      median = '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         if ((CNT_W'(i) < count) && (rank[i] == half)) begin
            median = vals[i];
         end
      end
   end

endmodule

/* src/pmaqi_aqi.sv */
module pmaqi_aqi (
   input  pmaqi_pkg::med_type pm25_tenths,
   output pmaqi_pkg::aqi_type aqi_tenths
);
   import pmaqi_pkg::*;

   logic [AQI_IN_W-1:0]                conc;
   logic [BAND_W-1:0]                  band;
   logic [AQI_SPAN_W-1:0]              span;
   logic [AQI_SPAN_W+AQI_SCALE_W-1:0]  scaled;

   // cap at the top breakpoint
   assign conc = (pm25_tenths > MED_W'(AQI_CAP)) ? AQI_CAP : pm25_tenths[AQI_IN_W-1:0];

   // lowest band whose top holds the value
   always_comb begin
      band = BAND_W'(AQI_BANDS - 1);
      for (int i = AQI_BANDS - 2; i >= 0; i--) begin
         if (conc <= AQI_TOP[i]) begin
            band = BAND_W'(i);
         end
      end
   end

   assign span   = AQI_SPAN_W'(conc - AQI_LO[band]);
   assign scaled = {{AQI_SCALE_W{1'b0}}, span} * {{AQI_SPAN_W{1'b0}}, AQI_SCALE[band]};

   assign aqi_tenths = AQI_W'(scaled >> AQI_FRAC_BITS) + AQI_BASE[band];

endmodule

/* src/particulate_median_aqi_pipeline_core.sv */
// Particulate median and AQI core. Each req transaction carries one sensor reading
// (pm1, pm2.5, pm10 in whole ug/m3) and yields exactly one rsp transaction with the
// running median of the last five readings per channel in tenths of ug/m3 (saturated
// to 65535), the EPA pm2.5 AQI times ten taken from the corrected pm2.5 median, and a
// sticky fault bit. pm2.5 gets a humidity correction before it enters the window:
// five times the reading when pm10 is nonzero and 5*pm2.5 exceeds 4*pm10, otherwise
// floor(pm2.5*440/53). Until five readings have arrived the median covers only the
// readings seen so far. The fault bit sets when each of the first three readings has
// pm2.5 of zero or above 500, and holds until reset. The core is a four-register
// pipeline (input register, window registers, median register, result register) and
// takes one transaction per clock while rsp keeps up; a reading passes in turn
// through the window, median and result registers before it shows up on rsp. Each
// stage has its own valid bit, so bubbles fill while rsp is stalled and req_tready
// drops only once every stage holds a reading. A reading updates the window as it
// leaves the input register, and the window registers feed the median stage.
module particulate_median_aqi_pipeline_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // pm1_raw[15:0], pm25_raw[31:16], pm10_raw[47:32]
   input  logic [pmaqi_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // pm1_median[15:0], pm25_median[31:16], pm10_median[47:32],
   // aqi_tenths[60:48], fault_flag[61], zero[63:62]
   output logic [pmaqi_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import pmaqi_pkg::*;

   // per-stage handshake
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   // input register
   raw_type pm1_s1_ff, pm25_s1_ff, pm10_s1_ff;

   // humidity correction
   logic [RAW_W+2:0]        pm25_x5;
   logic [RAW_W+2:0]        pm10_x4;
   logic                    wet_air;
   logic [CORR_PROD_W-1:0]  corr_prod;
   logic [CORR_QUOT_W-1:0]  corr_quot;
   med_type                 corr_dry;
   med_type                 corr_in;

   // reading window, undefined until written
   raw_type pm1_ring_ff  [WINDOW_DEPTH];
   med_type pm25_ring_ff [WINDOW_DEPTH];
   raw_type pm10_ring_ff [WINDOW_DEPTH];
   med_type pm1_ring_ext  [WINDOW_DEPTH];
   med_type pm10_ring_ext [WINDOW_DEPTH];

   slot_type slot_ff, slot_in;
   logic     full_ff, full_in;
   logic     slot_wrap;
   cnt_type  cnt_in;

   // self-test
   test_type test_cnt_ff, test_cnt_in;
   test_type fail_cnt_ff, fail_cnt_in;
   logic     fault_ff, fault_in;
   logic     test_bad;

   // window stage
   cnt_type cnt_s2_ff;
   logic    fault_s2_ff;

   // median stage
   med_type pm1_med, pm25_med, pm10_med;
   raw_type pm1_s3_ff, pm10_s3_ff;
   med_type pm25_s3_ff;
   logic    fault_s3_ff;

   // result stage
   logic [MED_W-1:0] pm1_x10, pm10_x10;
   raw_type          pm1_sat, pm25_sat, pm10_sat;
   aqi_type          aqi_in;
   raw_type          pm1_out_ff, pm25_out_ff, pm10_out_ff;
   aqi_type          aqi_out_ff;
   logic             fault_out_ff;

   // a stage takes a new reading when empty or when it hands its own on
   assign rdy4 = !v4_ff || rsp_tready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_tready = rdy1;
   assign rsp_tvalid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_tvalid) begin
         pm1_s1_ff  <= req_tdata[0 +: RAW_W];
         pm25_s1_ff <= req_tdata[RAW_W +: RAW_W];
         pm10_s1_ff <= req_tdata[2*RAW_W +: RAW_W];
      end
   end

   // wet air: pm10 nonzero and 5*pm2.5 above 4*pm10, then 5x
   assign pm25_x5 = {pm25_s1_ff, 2'b00} + {3'b000, pm25_s1_ff};
   assign pm10_x4 = {1'b0, pm10_s1_ff, 2'b00};
   assign wet_air = (pm10_s1_ff != '0) && (pm25_x5 > pm10_x4);

   // dry air: 440/53 = 8 + 16/53
   assign corr_prod = {{RECIP53_W{1'b0}}, pm25_s1_ff, 4'b0000} *
                      {{(RAW_W + 4){1'b0}}, RECIP53};
   assign corr_quot = corr_prod[RECIP53_SHIFT +: CORR_QUOT_W];
   assign corr_dry  = MED_W'({pm25_s1_ff, 3'b000}) + MED_W'(corr_quot);
   assign corr_in   = wet_air ? MED_W'(pm25_x5) : corr_dry;

   // window pointer and fill count including this reading
   assign slot_wrap = (slot_ff == SLOT_W'(WINDOW_DEPTH - 1));
   assign slot_in   = slot_wrap ? '0 : slot_ff + SLOT_W'(1);
   assign full_in   = full_ff || slot_wrap;
   assign cnt_in    = full_in ? CNT_W'(WINDOW_DEPTH) : CNT_W'(slot_ff) + CNT_W'(1);

   // self-test over the first few readings, then frozen
   assign test_bad = (pm25_s1_ff == '0) || (pm25_s1_ff > RAW_W'(SELF_TEST_MAX));

   always_comb begin
      test_cnt_in = test_cnt_ff;
      fail_cnt_in = fail_cnt_ff;
      fault_in    = fault_ff;
      if (test_cnt_ff < TEST_W'(SELFTEST_LEN)) begin
         test_cnt_in = test_cnt_ff + TEST_W'(1);
         fail_cnt_in = fail_cnt_ff + TEST_W'(test_bad);
         if ((test_cnt_in == TEST_W'(SELFTEST_LEN)) &&
             (fail_cnt_in == TEST_W'(SELFTEST_LEN))) begin
            fault_in = 1'b1;
         end
      end
   end

   // window state advances as a reading leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff     <= '0;
         full_ff     <= 1'b0;
         test_cnt_ff <= '0;
         fail_cnt_ff <= '0;
         fault_ff    <= 1'b0;
      end else if (rdy2 && v1_ff) begin
         slot_ff     <= slot_in;
         full_ff     <= full_in;
         test_cnt_ff <= test_cnt_in;
         fail_cnt_ff <= fail_cnt_in;
         fault_ff    <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         pm1_ring_ff[slot_ff]  <= pm1_s1_ff;
         pm25_ring_ff[slot_ff] <= corr_in;
         pm10_ring_ff[slot_ff] <= pm10_s1_ff;
         cnt_s2_ff             <= cnt_in;
         fault_s2_ff           <= fault_in;
      end
   end

   // medians over the filled window
   always_comb begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         pm1_ring_ext[i]  = MED_W'(pm1_ring_ff[i]);
         pm10_ring_ext[i] = MED_W'(pm10_ring_ff[i]);
      end
   end

   pmaqi_median u_pm1_median (
      .vals   (pm1_ring_ext),
      .count  (cnt_s2_ff),
      .median (pm1_med)
   );

   pmaqi_median u_pm25_median (
      .vals   (pm25_ring_ff),
      .count  (cnt_s2_ff),
      .median (pm25_med)
   );

   pmaqi_median u_pm10_median (
      .vals   (pm10_ring_ext),
      .count  (cnt_s2_ff),
      .median (pm10_med)
   );

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         pm1_s3_ff   <= pm1_med[RAW_W-1:0];
         pm25_s3_ff  <= pm25_med;
         pm10_s3_ff  <= pm10_med[RAW_W-1:0];
         fault_s3_ff <= fault_s2_ff;
      end
   end

   // tenths and saturation; aqi uses the unsaturated pm2.5 median
   assign pm1_x10  = MED_W'({pm1_s3_ff, 3'b000}) + MED_W'({pm1_s3_ff, 1'b0});
   assign pm10_x10 = MED_W'({pm10_s3_ff, 3'b000}) + MED_W'({pm10_s3_ff, 1'b0});
   assign pm1_sat  = (pm1_x10  > MED_W'({RAW_W{1'b1}})) ? '1 : pm1_x10[RAW_W-1:0];
   assign pm10_sat = (pm10_x10 > MED_W'({RAW_W{1'b1}})) ? '1 : pm10_x10[RAW_W-1:0];
   assign pm25_sat = (pm25_s3_ff > MED_W'({RAW_W{1'b1}})) ? '1 : pm25_s3_ff[RAW_W-1:0];

   pmaqi_aqi u_aqi (
      .pm25_tenths (pm25_s3_ff),
      .aqi_tenths  (aqi_in)
   );

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         pm1_out_ff   <= pm1_sat;
         pm25_out_ff  <= pm25_sat;
         pm10_out_ff  <= pm10_sat;
         aqi_out_ff   <= aqi_in;
         fault_out_ff <= fault_s3_ff;
      end
   end

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, fault_out_ff, aqi_out_ff,
                       pm10_out_ff, pm25_out_ff, pm1_out_ff};

   // window pointer stays inside the window
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff < SLOT_W'(WINDOW_DEPTH))
      else $error("window pointer out of range");

   // window must not move while its median is still pending
   a_window_hold: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !rdy3) |=> ($stable(slot_ff) && v2_ff))
      else $error("window written under a pending median");

   // fault is sticky
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      fault_ff |=> fault_ff)
      else $error("fault cleared without reset");

   // self-test counters stop at the test length
   a_test_bound: assert property (@(posedge clock) disable iff (reset)
      (test_cnt_ff <= TEST_W'(SELFTEST_LEN)) && (fail_cnt_ff <= test_cnt_ff))
      else $error("self-test counters out of range");

   // aqi never above its top value
   a_aqi_range: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> (aqi_out_ff <= AQI_W'(5000)))
      else $error("aqi above range");

endmodule

/* bench/particulate_median_aqi_pipeline_core_tb.sv */
`timescale 1ns / 100ps

module particulate_median_aqi_pipeline_core_tb;
   import pmaqi_pkg::*;

   // one expected report, compared field by field with rsp_tdata
   typedef struct packed {
      raw_type pm1_med;
      raw_type pm25_med;
      raw_type pm10_med;
      aqi_type aqi;
      logic    fault;
   } aqi_report_type;

   // one row of the directed table; want is only used when typed is set
   typedef struct packed {
      raw_type        pm1;
      raw_type        pm25;
      raw_type        pm10;
      logic           typed;
      aqi_report_type want;
   } stim_row_type;

   localparam int DIRECTED_N   = 24;
   localparam int PHASE_ITEMS  = 630;
   localparam int LONG_HOLD    = 60;
   localparam int DRAIN_CYCLES = 12;

   // directed readings: reset state, full scale, both self-test failure kinds,
   // the correction branch boundary, pm1 saturation edge, aqi band edges and cap
   localparam stim_row_type DIRECTED [DIRECTED_N] = '{
      '{16'd0,     16'd0,     16'd0,     1'b1, '{16'd0, 16'd0, 16'd0, 13'd0, 1'b0}},
      '{16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1,
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 13'd5000, 1'b0}},
      '{16'd0,     16'd501,   16'd0,     1'b0, '0},
      '{16'd1,     16'd500,   16'd0,     1'b0, '0},
      '{16'd2,     16'd1,     16'd1,     1'b0, '0},
      '{16'd3,     16'd4,     16'd5,     1'b0, '0},
      '{16'd4,     16'd5,     16'd6,     1'b0, '0},
      '{16'd5,     16'd0,     16'd7,     1'b0, '0},
      '{16'd6553,  16'd24,    16'd6553,  1'b0, '0},
      '{16'd6553,  16'd24,    16'd0,     1'b0, '0},
      '{16'd6554,  16'd24,    16'd6554,  1'b0, '0},
      '{16'd6554,  16'd24,    16'd10,    1'b0, '0},
      '{16'd6554,  16'd24,    16'd10,    1'b0, '0},
      '{16'd6554,  16'd24,    16'd10,    1'b0, '0},
      '{16'd7000,  16'd25,    16'd10,    1'b0, '0},
      '{16'd7000,  16'd25,    16'd10,    1'b0, '0},
      '{16'd7000,  16'd25,    16'd10,    1'b0, '0},
      '{16'd100,   16'd1000,  16'd1,     1'b0, '0},
      '{16'd100,   16'd1000,  16'd1,     1'b0, '0},
      '{16'd100,   16'd1000,  16'd1,     1'b0, '0},
      '{16'd100,   16'd1001,  16'd1,     1'b0, '0},
      '{16'd100,   16'd1001,  16'd1,     1'b0, '0},
      '{16'd100,   16'd1001,  16'd1,     1'b0, '0},
      '{16'd0,     16'd65535, 16'd0,     1'b0, '0}};

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // reports still owed by the block, oldest first
   aqi_report_type pending_reports [$];

   // predictor copy of the window and self-test state
   int unsigned win_pm1  [WINDOW_DEPTH];
   int unsigned win_pm25 [WINDOW_DEPTH];
   int unsigned win_pm10 [WINDOW_DEPTH];
   int unsigned win_slot;
   bit          win_full;
   int unsigned selftest_seen;
   int unsigned selftest_bad;
   bit          fault_held;

   // stimulus knobs and run statistics
   int req_idle_pct;
   int rsp_stall_pct;
   int hold_left;
   bit hold_armed;
   bit hold_taken;
   int run_left;
   int run_level;
   int run_branch;
   int readings_sent;
   int reports_checked;
   int backpressure_cycles;
   int mismatch_count;

   particulate_median_aqi_pipeline_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // generous cap on the whole run
   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   function automatic raw_type clip16(input int unsigned v);
      return (v > 65535) ? 16'hFFFF : raw_type'(v);
   endfunction

   // upper median of the first n window entries, by insertion sort
   function automatic int unsigned upper_median_of(input int unsigned win [WINDOW_DEPTH],
                                                   input int unsigned n);
      int unsigned s [WINDOW_DEPTH];
      int unsigned v;
      int          j;
      for (int i = 0; i < n; i++) begin
         v = win[i];
         j = i;
         while (j > 0 && s[j-1] > v) begin
            s[j] = s[j-1];
            j--;
         end
         s[j] = v;
      end
      return s[n/2];
   endfunction

   // epa pm2.5 piecewise-linear index, input and output in tenths
   function automatic aqi_type aqi_from_pm25(input int unsigned t);
      int unsigned cl, ch, al, ah;
      if (t > 5004) t = 5004;
      if (t <= 120) begin
         cl = 0;    ch = 120;  al = 0;   ah = 50;
      end else if (t <= 354) begin
         cl = 121;  ch = 354;  al = 51;  ah = 100;
      end else if (t <= 554) begin
         cl = 355;  ch = 554;  al = 101; ah = 150;
      end else if (t <= 1504) begin
         cl = 555;  ch = 1504; al = 151; ah = 200;
      end else if (t <= 2504) begin
         cl = 1505; ch = 2504; al = 201; ah = 300;
      end else if (t <= 3504) begin
         cl = 2505; ch = 3504; al = 301; ah = 400;
      end else begin
         cl = 3505; ch = 5004; al = 401; ah = 500;
      end
      return aqi_type'(((ah - al) * (t - cl) * 10) / (ch - cl) + al * 10);
   endfunction

   // advance the predictor by one accepted reading and return its report
   function automatic aqi_report_type predict_report(input raw_type p1, input raw_type p25,
                                                     input raw_type p10);
      int unsigned a1, a25, a10, corr, filled, m25;
      aqi_report_type r;
      a1  = p1;
      a25 = p25;
      a10 = p10;
      // self-test looks only at the first few readings after reset
      if (selftest_seen < SELFTEST_LEN) begin
         if (a25 > SELF_TEST_MAX || a25 == 0) selftest_bad++;
         selftest_seen++;
         if (selftest_seen == SELFTEST_LEN && selftest_bad == SELFTEST_LEN)
            fault_held = 1'b1;
      end
      // humid-air correction vs dry-air scaling
      if (a10 != 0 && 5 * a25 > 4 * a10) corr = a25 * 5;
      else corr = (a25 * 440) / 53;
      win_pm1[win_slot]  = a1;
      win_pm25[win_slot] = corr & 32'hFFFFF;
      win_pm10[win_slot] = a10;
      win_slot++;
      if (win_slot >= WINDOW_DEPTH) begin
         win_slot = 0;
         win_full = 1'b1;
      end
      filled     = win_full ? WINDOW_DEPTH : win_slot;
      m25        = upper_median_of(win_pm25, filled);
      r.pm1_med  = clip16(upper_median_of(win_pm1, filled) * 10);
      r.pm25_med = clip16(m25);
      r.pm10_med = clip16(upper_median_of(win_pm10, filled) * 10);
      r.aqi      = aqi_from_pm25(m25);
      r.fault    = fault_held;
      return r;
   endfunction

   // sender gaps, with junk on tdata while tvalid is low
   task automatic idle_sender();
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_TDATA_W'({$urandom(), $urandom()});
         @(posedge clock);
      end
   endtask

   // offer one reading and hold it until the block takes it
   task automatic send_reading(input raw_type p1, input raw_type p25, input raw_type p10,
                               input logic typed, input aqi_report_type want);
      aqi_report_type r;
      req_tdata  <= {p10, p25, p1};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      r = predict_report(p1, p25, p10);
      if (typed) r = want;
      pending_reports.push_back(r);
      readings_sent++;
   endtask

   // mostly short runs of similar readings so the medians settle into each aqi
   // band, with single full-range readings mixed in as noise
   task automatic next_random(output raw_type p1, output raw_type p25, output raw_type p10);
      int a1, a25, a10;
      if (run_left == 0) begin
         if ($urandom_range(4) == 0) begin
            p1  = raw_type'($urandom());
            p25 = raw_type'($urandom());
            p10 = raw_type'($urandom());
            return;
         end
         run_left = $urandom_range(3, 6);
         case ($urandom_range(3))
            0: run_level = $urandom_range(0, 30);
            1: run_level = $urandom_range(0, 120);
            2: run_level = $urandom_range(0, 1100);
            default: run_level = $urandom_range(0, 14000);
         endcase
         run_branch = $urandom_range(2);
      end
      run_left--;
      a25 = run_level + $urandom_range(0, 2);
      case (run_branch)
         0: a10 = 0;
         // straddle the 5*pm25 vs 4*pm10 boundary
         1: a10 = (a25 * 5) / 4 + $urandom_range(0, 2) - 1;
         default: a10 = a25 + $urandom_range(0, a25 + 5);
      endcase
      a1 = $urandom_range(0, a25 + 1);
      if (a10 < 0) a10 = 0;
      p1  = clip16(a1);
      p25 = clip16(a25);
      p10 = clip16(a10);
   endtask

   // receiver: random stalls, plus one long hold counted here that fills the pipe
   always @(posedge clock) begin
      if (hold_armed && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // compare every rsp transaction with the oldest owed report
   always @(posedge clock) begin
      aqi_report_type want;
      if (!reset && req_tvalid && !req_tready) backpressure_cycles++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            flag_mismatch($sformatf("report with nothing owed, tdata %h", rsp_tdata));
         end else begin
            want = pending_reports.pop_front();
            if (rsp_tdata[15:0] !== want.pm1_med)
               flag_mismatch($sformatf("report %0d pm1 median %h, want %h",
                  reports_checked, rsp_tdata[15:0], want.pm1_med));
            if (rsp_tdata[31:16] !== want.pm25_med)
               flag_mismatch($sformatf("report %0d pm2.5 median %h, want %h",
                  reports_checked, rsp_tdata[31:16], want.pm25_med));
            if (rsp_tdata[47:32] !== want.pm10_med)
               flag_mismatch($sformatf("report %0d pm10 median %h, want %h",
                  reports_checked, rsp_tdata[47:32], want.pm10_med));
            if (rsp_tdata[60:48] !== want.aqi)
               flag_mismatch($sformatf("report %0d aqi %0d, want %0d",
                  reports_checked, rsp_tdata[60:48], want.aqi));
            if (rsp_tdata[61] !== want.fault)
               flag_mismatch($sformatf("report %0d fault %b, want %b",
                  reports_checked, rsp_tdata[61], want.fault));
            if (rsp_tdata[63:62] !== 2'b00)
               flag_mismatch($sformatf("report %0d pad bits %b",
                  reports_checked, rsp_tdata[63:62]));
            reports_checked++;
         end
      end
   end

   initial begin
      raw_type p1, p25, p10;
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      rsp_tready    <= 1'b0;
      hold_armed    <= 1'b0;
      hold_taken    = 1'b0;
      hold_left     = 0;
      win_slot      = 0;
      win_full      = 1'b0;
      selftest_seen = 0;
      selftest_bad  = 0;
      fault_held    = 1'b0;
      run_left      = 0;
      // sender mostly busy, receiver stalling more often than not
      req_idle_pct  = 6;
      rsp_stall_pct = 58;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_N; i++) begin
         idle_sender();
         send_reading(DIRECTED[i].pm1, DIRECTED[i].pm25, DIRECTED[i].pm10,
                      DIRECTED[i].typed, DIRECTED[i].want);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct  = 6;
               rsp_stall_pct = 58;
            end
            1: begin
               req_idle_pct  = 58;
               rsp_stall_pct = 6;
            end
            default: begin
               // no gaps either side, and one long receiver hold with the
               // sender still offering so req_tready has to drop
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
               hold_armed   <= 1'b1;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            idle_sender();
            next_random(p1, p25, p10);
            send_reading(p1, p25, p10, 1'b0, '0);
         end
      end
      req_tvalid <= 1'b0;

      while (pending_reports.size() != 0) @(posedge clock);
      // catch anything extra the block might still push out
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d readings (directed extremes, self-test fault, aqi bands)",
               readings_sent);
      $display("%0d reports compared, %0d cycles with req held off by the block",
               reports_checked, backpressure_cycles);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
